FILE: rtl/core/rvx_pkg.sv
// Shared opcodes, result codes and word structs for the RV32I execute unit.
package rvx_pkg;

  localparam int XLEN = 32;
  localparam int OP_W = 6;
  localparam int REG_W = 5;
  localparam int KIND_W = 4;
  localparam int EVENT_W = 2;

  localparam logic [XLEN-1:0] SHIFT_MASK = 32'h0000_001F;
  localparam logic [XLEN-1:0] BYTE_MASK = 32'h0000_00FF;
  localparam logic [XLEN-1:0] HALF_MASK = 32'h0000_FFFF;
  localparam logic [XLEN-1:0] INSN_BYTES = 32'd4;

  localparam logic [OP_W-1:0] OP_LB = 6'd0;
  localparam logic [OP_W-1:0] OP_LH = 6'd1;
  localparam logic [OP_W-1:0] OP_LW = 6'd2;
  localparam logic [OP_W-1:0] OP_LBU = 6'd3;
  localparam logic [OP_W-1:0] OP_LHU = 6'd4;
  localparam logic [OP_W-1:0] OP_ADDI = 6'd5;
  localparam logic [OP_W-1:0] OP_SLTI = 6'd6;
  localparam logic [OP_W-1:0] OP_SLTIU = 6'd7;
  localparam logic [OP_W-1:0] OP_XORI = 6'd8;
  localparam logic [OP_W-1:0] OP_ORI = 6'd9;
  localparam logic [OP_W-1:0] OP_ANDI = 6'd10;
  localparam logic [OP_W-1:0] OP_SLLI = 6'd11;
  localparam logic [OP_W-1:0] OP_SRLI = 6'd12;
  localparam logic [OP_W-1:0] OP_SRAI = 6'd13;
  localparam logic [OP_W-1:0] OP_AUIPC = 6'd14;
  localparam logic [OP_W-1:0] OP_LUI = 6'd15;
  localparam logic [OP_W-1:0] OP_SB = 6'd16;
  localparam logic [OP_W-1:0] OP_SH = 6'd17;
  localparam logic [OP_W-1:0] OP_SW = 6'd18;
  localparam logic [OP_W-1:0] OP_ADD = 6'd19;
  localparam logic [OP_W-1:0] OP_SUB = 6'd20;
  localparam logic [OP_W-1:0] OP_SLL = 6'd21;
  localparam logic [OP_W-1:0] OP_SLT = 6'd22;
  localparam logic [OP_W-1:0] OP_SLTU = 6'd23;
  localparam logic [OP_W-1:0] OP_XOR = 6'd24;
  localparam logic [OP_W-1:0] OP_SRL = 6'd25;
  localparam logic [OP_W-1:0] OP_SRA = 6'd26;
  localparam logic [OP_W-1:0] OP_OR = 6'd27;
  localparam logic [OP_W-1:0] OP_AND = 6'd28;
  localparam logic [OP_W-1:0] OP_BEQ = 6'd29;
  localparam logic [OP_W-1:0] OP_BNE = 6'd30;
  localparam logic [OP_W-1:0] OP_BLT = 6'd31;
  localparam logic [OP_W-1:0] OP_BGE = 6'd32;
  localparam logic [OP_W-1:0] OP_BLTU = 6'd33;
  localparam logic [OP_W-1:0] OP_BGEU = 6'd34;
  localparam logic [OP_W-1:0] OP_JAL = 6'd35;
  localparam logic [OP_W-1:0] OP_JALR = 6'd36;
  localparam logic [OP_W-1:0] OP_ECALL = 6'd37;
  localparam logic [OP_W-1:0] OP_EBREAK = 6'd38;

  localparam logic [KIND_W-1:0] MEM_NONE = 4'd0;
  localparam logic [KIND_W-1:0] MEM_LB = 4'd1;
  localparam logic [KIND_W-1:0] MEM_LH = 4'd2;
  localparam logic [KIND_W-1:0] MEM_LW = 4'd3;
  localparam logic [KIND_W-1:0] MEM_LBU = 4'd4;
  localparam logic [KIND_W-1:0] MEM_LHU = 4'd5;
  localparam logic [KIND_W-1:0] MEM_SB = 4'd6;
  localparam logic [KIND_W-1:0] MEM_SH = 4'd7;
  localparam logic [KIND_W-1:0] MEM_SW = 4'd8;

  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_ECALL = 2'd1;
  localparam logic [EVENT_W-1:0] EV_EBREAK = 2'd2;
  localparam logic [EVENT_W-1:0] EV_INVALID = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [REG_W-1:0] dest_reg;
    logic [XLEN-1:0]  rs1_value;
    logic [XLEN-1:0]  rs2_value;
    logic [XLEN-1:0]  imm;
    logic [XLEN-1:0]  pc;
  } exec_in_t;

  typedef struct packed {
    logic [XLEN-1:0]    rd_value;
    logic               rd_write;
    logic [REG_W-1:0]   write_reg;
    logic [XLEN-1:0]    next_pc;
    logic [KIND_W-1:0]  mem_kind;
    logic [XLEN-1:0]    mem_address;
    logic [XLEN-1:0]    store_data;
    logic [EVENT_W-1:0] event_res;
  } exec_out_t;

endpackage

FILE: rtl/core/rvx_alu.sv
// Combinational execute logic: ALU, branch compare, jump targets, memory request.
module rvx_alu
  import rvx_pkg::*;
(
  input  exec_in_t  in_word,
  output exec_out_t out_word
);

  logic [XLEN-1:0] a;
  logic [XLEN-1:0] b;
  logic [XLEN-1:0] im;
  logic [XLEN-1:0] pc_plus4;
  logic [XLEN-1:0] pc_target;
  logic [XLEN-1:0] addr;
  logic [4:0]      sh_imm;
  logic [4:0]      sh_reg;
  logic            taken;

  assign a = in_word.rs1_value;
  assign b = in_word.rs2_value;
  assign im = in_word.imm;
  assign pc_plus4 = in_word.pc + INSN_BYTES;
  assign pc_target = in_word.pc + im;
  assign addr = a + im;
  assign sh_imm = im[4:0];
  assign sh_reg = b[4:0];

  always_comb begin
    out_word = '0;
    out_word.write_reg = in_word.dest_reg;
    out_word.next_pc = pc_plus4;
    taken = 1'b0;
    unique case (in_word.op)
      OP_LB:     begin out_word.mem_kind = MEM_LB;  out_word.mem_address = addr; end
      OP_LH:     begin out_word.mem_kind = MEM_LH;  out_word.mem_address = addr; end
      OP_LW:     begin out_word.mem_kind = MEM_LW;  out_word.mem_address = addr; end
      OP_LBU:    begin out_word.mem_kind = MEM_LBU; out_word.mem_address = addr; end
      OP_LHU:    begin out_word.mem_kind = MEM_LHU; out_word.mem_address = addr; end
      OP_ADDI:   begin out_word.rd_value = addr; out_word.rd_write = 1'b1; end
      OP_SLTI: begin
        out_word.rd_value = {31'd0, $signed(a) < $signed(im)};
        out_word.rd_write = 1'b1;
      end
      OP_SLTIU:  begin out_word.rd_value = {31'd0, a < im}; out_word.rd_write = 1'b1; end
      OP_XORI:   begin out_word.rd_value = a ^ im; out_word.rd_write = 1'b1; end
      OP_ORI:    begin out_word.rd_value = a | im; out_word.rd_write = 1'b1; end
      OP_ANDI:   begin out_word.rd_value = a & im; out_word.rd_write = 1'b1; end
      OP_SLLI:   begin out_word.rd_value = a << sh_imm; out_word.rd_write = 1'b1; end
      OP_SRLI:   begin out_word.rd_value = a >> sh_imm; out_word.rd_write = 1'b1; end
      OP_SRAI: begin
        out_word.rd_value = $unsigned($signed(a) >>> sh_imm);
        out_word.rd_write = 1'b1;
      end
      OP_AUIPC:  begin out_word.rd_value = pc_target; out_word.rd_write = 1'b1; end
      OP_LUI:    begin out_word.rd_value = im; out_word.rd_write = 1'b1; end
      OP_SB: begin
        out_word.mem_kind = MEM_SB;
        out_word.mem_address = addr;
        out_word.store_data = b & BYTE_MASK;
      end
      OP_SH: begin
        out_word.mem_kind = MEM_SH;
        out_word.mem_address = addr;
        out_word.store_data = b & HALF_MASK;
      end
      OP_SW: begin
        out_word.mem_kind = MEM_SW;
        out_word.mem_address = addr;
        out_word.store_data = b;
      end
      OP_ADD:    begin out_word.rd_value = a + b; out_word.rd_write = 1'b1; end
      OP_SUB:    begin out_word.rd_value = a - b; out_word.rd_write = 1'b1; end
      OP_SLL:    begin out_word.rd_value = a << sh_reg; out_word.rd_write = 1'b1; end
      OP_SLT: begin
        out_word.rd_value = {31'd0, $signed(a) < $signed(b)};
        out_word.rd_write = 1'b1;
      end
      OP_SLTU:   begin out_word.rd_value = {31'd0, a < b}; out_word.rd_write = 1'b1; end
      OP_XOR:    begin out_word.rd_value = a ^ b; out_word.rd_write = 1'b1; end
      OP_SRL:    begin out_word.rd_value = a >> sh_reg; out_word.rd_write = 1'b1; end
      OP_SRA: begin
        out_word.rd_value = $unsigned($signed(a) >>> sh_reg);
        out_word.rd_write = 1'b1;
      end
      OP_OR:     begin out_word.rd_value = a | b; out_word.rd_write = 1'b1; end
      OP_AND:    begin out_word.rd_value = a & b; out_word.rd_write = 1'b1; end
      OP_BEQ:    taken = (a == b);
      OP_BNE:    taken = (a != b);
      OP_BLT:    taken = ($signed(a) < $signed(b));
      OP_BGE:    taken = ($signed(a) >= $signed(b));
      OP_BLTU:   taken = (a < b);
      OP_BGEU:   taken = (a >= b);
      OP_JAL: begin
        out_word.rd_value = pc_plus4;
        out_word.rd_write = 1'b1;
        out_word.next_pc = pc_target;
      end
      OP_JALR: begin
        out_word.rd_value = pc_plus4;
        out_word.rd_write = 1'b1;
        out_word.next_pc = {addr[XLEN-1:1], 1'b0};
      end
      OP_ECALL:  out_word.event_res = EV_ECALL;
      OP_EBREAK: out_word.event_res = EV_EBREAK;
      default:   out_word.event_res = EV_INVALID;
    endcase
    if (taken) begin
      out_word.next_pc = pc_target;
    end
  end

endmodule

FILE: rtl/core/rvx_skid.sv
// Result register with a spare entry so the upstream ready is a register.
module rvx_skid
  import rvx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  exec_out_t in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output exec_out_t out_word
);

  logic      main_valid;
  logic      spare_valid;
  exec_out_t main_word;
  exec_out_t spare_word;
  logic      take;
  logic      drain;

  assign in_ready = !spare_valid;
  assign take = in_valid && in_ready;
  assign drain = out_ready || !main_valid;
  assign out_valid = main_valid;
  assign out_word = main_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      spare_valid <= 1'b0;
    end else if (drain) begin
      main_valid <= spare_valid || take;
      spare_valid <= 1'b0;
    end else if (take) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      main_word <= spare_valid ? spare_word : in_word;
    end else if (take) begin
      spare_word <= in_word;
    end
  end

endmodule

FILE: rtl/core/rv32i_execute_unit.sv
// Top level of the RV32I execute unit: input register, execute logic, result register.
//
// One decoded instruction per word enters on the s_ side; one result word
// leaves on the m_ side for every instruction, in order.
// s_tuser carries the operation code; s_tdata the operands and pc.
// m_tdata carries the register write, next pc and memory request;
// m_tuser the memory access kind and the event code.
// An accepted word goes into the input register and then into the result register,
// which drives m_tvalid. Throughput: one word per cycle while m_tready stays high;
// the execute logic sits between the two registers and is combinational.
// Reset clears both stages; s_tready is high in the first cycle after it.
// When the receiver holds m_tready low, the result register keeps its word
// and a spare entry takes the word already in the input register; s_tready
// then drops (it comes from registers only) and rises again as the output
// drains. No word is lost or repeated under any stall pattern.
// Loads only issue the request; the loaded data is written back elsewhere.
module rv32i_execute_unit
  import rvx_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [135:133] zero, [132:101] pc, [100:69] imm, [68:37] rs2_value,
  // [36:5] rs1_value, [4:0] dest_reg
  input  logic [135:0] s_tdata,
  // [5:0] op
  input  logic [5:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [135:134] zero, [133:102] store_data, [101:70] mem_address,
  // [69:38] next_pc, [37:33] write_reg, [32] rd_write, [31:0] rd_value
  output logic [135:0] m_tdata,
  // [5:4] event_res, [3:0] mem_kind
  output logic [5:0]   m_tuser
);

  logic      in_valid;
  exec_in_t  in_word;
  exec_out_t exec_word;
  exec_out_t res_word;
  logic      sk_ready;

  assign s_tready = !in_valid || sk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word.op <= s_tuser;
      in_word.dest_reg <= s_tdata[4:0];
      in_word.rs1_value <= s_tdata[36:5];
      in_word.rs2_value <= s_tdata[68:37];
      in_word.imm <= s_tdata[100:69];
      in_word.pc <= s_tdata[132:101];
    end
  end

  rvx_alu u_alu (
    .in_word  (in_word),
    .out_word (exec_word)
  );

  rvx_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (sk_ready),
    .in_word   (exec_word),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (res_word)
  );

  assign m_tdata = {2'b00, res_word.store_data, res_word.mem_address, res_word.next_pc,
                    res_word.write_reg, res_word.rd_write, res_word.rd_value};
  assign m_tuser = {res_word.event_res, res_word.mem_kind};

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !sk_ready |=> in_valid && $stable(in_word))
    else $error("input stage word dropped while result side full");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res_word.rd_write |-> res_word.rd_value == '0)
    else $error("rd_value nonzero without rd_write");

  a_addr_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_word.mem_kind == MEM_NONE |-> res_word.mem_address == '0)
    else $error("mem_address nonzero without memory request");

  a_event_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_word.event_res != EV_NONE
      |-> !res_word.rd_write && res_word.mem_kind == MEM_NONE)
    else $error("event word has register or memory effect");

endmodule
